// ===== rtl/mse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the merge sort engine.
// No dependencies; imported by mse_merge, merge_sort_engine_core and the testbench.
package mse_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 10;
  localparam int S_TDATA_W     = 48;
  localparam int M_TDATA_W     = 32;
  localparam int DEF_MAX_ITEMS = 1024;

  // Request kinds carried on s_tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Bank select: bank A holds loaded values, bank B is the merge scratch
  localparam logic BANK_A = 1'b0;
  localparam logic BANK_B = 1'b1;

  // Status from the merge sequencer to the top level
  typedef struct packed {
    logic busy;   // sequencer owns both banks
    logic done;   // one-cycle pulse when the set is sorted
    logic bank;   // bank that holds the current result
  } mse_stat_t;

endpackage

// ===== rtl/mse_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mse_merge.sv =====
`timescale 1ns / 1ps
// Bottom-up merge sequencer around one shared signed compare unit.
// Ping-pongs between two RAM banks; depends on mse_pkg.
module mse_merge
  import mse_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] n,
  input  logic [DATA_W-1:0]            rdata,
  output logic [$clog2(MAX_ITEMS)-1:0] raddr,
  output logic                         we,
  output logic                         wbank,
  output logic [$clog2(MAX_ITEMS)-1:0] waddr,
  output logic [DATA_W-1:0]            wdata,
  output mse_stat_t                    stat
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int WW = CW + 2;

  typedef enum logic [2:0] {
    M_IDLE, M_RUN, M_GETP, M_GETQ, M_CMP, M_GET
  } mstate_t;

  mstate_t            state;
  logic [WW-1:0]      nreg, width, lo, mid, hi, p, q, k;
  logic signed [DATA_W-1:0] hp, hq;
  logic               side_p;
  logic               bank;
  logic               done;

  logic [WW-1:0] mid_next, hi_next, lo_step, w2;
  logic          take_p;

  assign w2       = width << 1;
  assign lo_step  = lo + w2;
  assign mid_next = ((lo + width) > nreg) ? nreg : (lo + width);
  assign hi_next  = (lo_step > nreg) ? nreg : lo_step;
  assign take_p   = (p < mid) && ((q >= hi) || (hp <= hq));

  always_comb begin
    raddr = lo[AW-1:0];
    unique case (state)
      M_GETP:  raddr = q[AW-1:0];
      M_CMP:   raddr = take_p ? AW'(p + 1'b1) : AW'(q + 1'b1);
      default: raddr = lo[AW-1:0];
    endcase
  end

  assign we    = (state == M_CMP);
  assign wbank = ~bank;
  assign waddr = k[AW-1:0];
  assign wdata = take_p ? hp : hq;

  assign stat.busy = (state != M_IDLE);
  assign stat.done = done;
  assign stat.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      bank  <= BANK_A;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            nreg  <= WW'(n);
            width <= WW'(1);
            lo    <= '0;
            bank  <= BANK_A;
            if (n <= CW'(1)) begin
              done <= 1'b1;
            end else begin
              state <= M_RUN;
            end
          end
        end
        M_RUN: begin
          if (lo >= nreg) begin
            // pass complete: result now sits in the other bank
            bank  <= ~bank;
            width <= w2;
            lo    <= '0;
            if (w2 >= nreg) begin
              done  <= 1'b1;
              state <= M_IDLE;
            end
          end else begin
            mid   <= mid_next;
            hi    <= hi_next;
            p     <= lo;
            q     <= mid_next;
            k     <= lo;
            state <= M_GETP;
          end
        end
        M_GETP: begin
          hp    <= rdata;
          state <= M_GETQ;
        end
        M_GETQ: begin
          hq    <= rdata;
          state <= M_CMP;
        end
        M_CMP: begin
          k      <= k + 1'b1;
          side_p <= take_p;
          if (take_p) begin
            p <= p + 1'b1;
          end else begin
            q <= q + 1'b1;
          end
          if ((k + 1'b1) == hi) begin
            lo    <= lo_step;
            state <= M_RUN;
          end else begin
            state <= M_GET;
          end
        end
        M_GET: begin
          if (side_p) begin
            hp <= rdata;
          end else begin
            hq <= rdata;
          end
          state <= M_CMP;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  // The write pointer never runs past the end of the current run
  a_k_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == M_CMP) |-> (k < hi))
    else $error("merge write pointer past run end");

  a_p_in_left: assert property (@(posedge clk) disable iff (rst)
    (state == M_CMP) |-> (p <= mid))
    else $error("left run pointer past run boundary");

  a_q_in_right: assert property (@(posedge clk) disable iff (rst)
    (state == M_CMP) |-> (q <= hi))
    else $error("right run pointer past run end");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == M_IDLE))
    else $error("sort completion while sequencer active");

endmodule

// ===== rtl/merge_sort_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the merge sort engine: stream ports, load/read control, two RAM banks.
// Depends on mse_pkg, mse_ram and mse_merge.
//
//  channel | direction | tdata                                     | tuser          | tlast
//  s_*     | in        | [31:0] value, [41:32] read_index, pad     | req_type       | last_item
//  m_*     | out       | [31:0] sorted_value                       | index_error    | -
//
// A load is written to bank A as it is accepted, unless the bank is full. A read goes
// through T_RD to T_OUT (straight to T_OUT when the index check fails), plus any wait for
// the output register to free up. The last load starts the sort, which makes ceil(log2(n))
// passes through the shared compare unit and the single read port of the source bank,
// during which s_tready is low. Reset clears the count and sorted flag; RAM contents are
// not cleared. The output register holds a result until m_tready takes it.
module merge_sort_engine_core
  import mse_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value, [41:32] read_index, [47:42] zero
  input  logic                 s_tuser,   // [0] req_type
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                 m_tuser    // [0] index_error
);

  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {T_IDLE, T_SORT, T_RD, T_OUT} tstate_t;

  tstate_t          state;
  logic [CW-1:0]    count;
  logic             sorted;
  logic [DATA_W-1:0] hold_val;
  logic             hold_err;

  // Input field views
  logic [DATA_W-1:0] in_value;
  logic [IDX_W-1:0]  in_idx;
  logic              accept;
  logic              is_load, is_read;
  logic [CW-1:0]     cnt_eff, cnt_new;
  logic              room;
  logic              rd_err;

  assign in_value = s_tdata[DATA_W-1:0];
  assign in_idx   = s_tdata[DATA_W+IDX_W-1:DATA_W];
  assign s_tready = (state == T_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = accept && (s_tuser == REQ_LOAD);
  assign is_read  = accept && (s_tuser == REQ_READ);

  // A load after a finished sort starts a new set
  assign cnt_eff = sorted ? '0 : count;
  assign room    = (cnt_eff < CW'(MAX_ITEMS));
  assign cnt_new = room ? (cnt_eff + 1'b1) : cnt_eff;

  assign rd_err = !sorted
               || (CMPW'(in_idx) >= CMPW'(count))
               || (CMPW'(in_idx) >= CMPW'(MAX_ITEMS));

  // Merge sequencer
  mse_stat_t         stat;
  logic [AW-1:0]     m_raddr, m_waddr;
  logic              m_we, m_wbank;
  logic [DATA_W-1:0] m_wdata;
  logic [DATA_W-1:0] rdata, rdata_a, rdata_b;
  logic              sort_start;

  assign sort_start = is_load && s_tlast;

  mse_merge #(.MAX_ITEMS(MAX_ITEMS)) u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (sort_start),
    .n     (cnt_new),
    .rdata (rdata),
    .raddr (m_raddr),
    .we    (m_we),
    .wbank (m_wbank),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .stat  (stat)
  );

  // Bank ports: loads write bank A, the sequencer writes whichever bank is the target
  logic              we_a, we_b;
  logic [AW-1:0]     waddr_a, raddr_x;
  logic [DATA_W-1:0] wdata_a;

  assign we_a    = (is_load && room) || (m_we && (m_wbank == BANK_A));
  assign we_b    = m_we && (m_wbank == BANK_B);
  assign waddr_a = stat.busy ? m_waddr : cnt_eff[AW-1:0];
  assign wdata_a = stat.busy ? m_wdata : in_value;
  assign raddr_x = stat.busy ? m_raddr : AW'(in_idx);
  assign rdata   = (stat.bank == BANK_B) ? rdata_b : rdata_a;

  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr_x),
    .rdata (rdata_a)
  );

  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (raddr_x),
    .rdata (rdata_b)
  );

  // Control: one item at a time, output register decoupled from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      count    <= '0;
      sorted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is loaded this cycle
      if (m_tvalid && m_tready && (state != T_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (is_load) begin
            count  <= cnt_new;
            sorted <= 1'b0;
            if (s_tlast) begin
              state <= T_SORT;
            end
          end else if (is_read) begin
            if (rd_err) begin
              hold_val <= '0;
              hold_err <= 1'b1;
              state    <= T_OUT;
            end else begin
              state <= T_RD;
            end
          end
        end
        T_SORT: begin
          // hold until the sequencer reports the set sorted
          if (stat.done) begin
            sorted <= 1'b1;
            state  <= T_IDLE;
          end
        end
        T_RD: begin
          hold_val <= rdata;
          hold_err <= 1'b0;
          state    <= T_OUT;
        end
        T_OUT: begin
          // advance once the output register is free or being drained
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= hold_val;
            m_tuser  <= hold_err;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !s_tready)
    else $error("input accepted while sort running");

  a_read_needs_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == T_RD) |-> sorted)
    else $error("store read on unsorted set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count past capacity");

  a_done_in_sort: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == T_SORT))
    else $error("sort completion outside sort state");

endmodule

// ===== verif/merge_sort_engine_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for merge_sort_engine_core: directed and random load/read traffic.
// Depends on mse_pkg and the merge_sort_engine_core RTL with its mse_ram and mse_merge submodules.
module merge_sort_engine_core_test
  import mse_pkg::*;
();

  localparam int CAPACITY    = DEF_MAX_ITEMS;
  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;
  localparam int PAD_W       = S_TDATA_W - DATA_W - IDX_W;
  // Keep both sides busy without gaps inside this window of cycles.
  localparam int QUIET_FROM  = 300;
  localparam int QUIET_TO    = 4000;

  typedef struct {
    logic                     kind;      // REQ_LOAD or REQ_READ
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [IDX_W-1:0]         index;
    bit                       drain;     // hold back until all read results are back
  } sort_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     err;
  } read_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = REQ_LOAD;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  sort_req_t   pending_reqs[$];
  sort_req_t   req_on_bus;
  read_reply_t reply_queue[$];
  read_reply_t reply_due;

  // Predictor state: values of the current set, and whether it has been sorted.
  logic signed [DATA_W-1:0] set_vals[$];
  bit                       set_done = 1'b0;

  int  cycle = 0;
  int  reads_issued = 0;
  int  results_seen = 0;
  int  error_count = 0;
  bit  timed_out = 1'b0;

  merge_sort_engine_core #(.MAX_ITEMS(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic bit take_break();
    if (cycle >= QUIET_FROM && cycle < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  function automatic void push_load(logic signed [DATA_W-1:0] v, logic last, bit drain);
    sort_req_t r;
    r.kind  = REQ_LOAD;
    r.value = v;
    r.last  = last;
    r.index = IDX_W'($urandom);  // ignored on loads: fill with noise
    r.drain = drain;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_read(int unsigned idx, bit drain);
    sort_req_t r;
    r.kind  = REQ_READ;
    r.value = $urandom;          // ignored on reads: fill with noise
    r.last  = 1'($urandom_range(0, 1));
    r.index = IDX_W'(idx);
    r.drain = drain;
    pending_reqs.push_back(r);
  endfunction

  // Mix full-range values, a narrow band that yields many duplicates, and the extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 16)) - 8;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Ascending insertion sort of the current set.
  function automatic void order_set();
    int i;
    int j;
    logic signed [DATA_W-1:0] key;
    for (i = 1; i < set_vals.size(); i++) begin
      key = set_vals[i];
      j = i - 1;
      while (j >= 0 && set_vals[j] > key) begin
        set_vals[j + 1] = set_vals[j];
        j--;
      end
      set_vals[j + 1] = key;
    end
  endfunction

  // Advance the predictor by one accepted item; queue the reply a read must produce.
  function automatic void predict_sort(sort_req_t r);
    read_reply_t rep;
    if (r.kind == REQ_LOAD) begin
      if (set_done) begin
        set_vals.delete();
        set_done = 1'b0;
      end
      if (set_vals.size() < CAPACITY) set_vals.push_back(r.value);
      if (r.last) begin
        order_set();
        set_done = 1'b1;
      end
    end else begin
      if (!set_done || r.index >= set_vals.size()) begin
        rep.value = '0;
        rep.err   = 1'b1;
      end else begin
        rep.value = set_vals[r.index];
        rep.err   = 1'b0;
      end
      reply_queue.push_back(rep);
      reads_issued++;
    end
  endfunction

  // Driver: record the accepted item, then present the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= REQ_LOAD;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_sort(req_on_bus);
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !take_break() &&
            (!pending_reqs[0].drain || reads_issued == results_seen)) begin
          req_on_bus = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{PAD_W{1'b0}}, req_on_bus.index, req_on_bus.value};
          s_tuser  <= req_on_bus.kind;
          s_tlast  <= req_on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted reply against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (reply_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected reply value=%0d err=%0b", $time,
                   $signed(m_tdata), m_tuser);
        end else begin
          reply_due = reply_queue.pop_front();
          if (m_tdata !== reply_due.value) begin
            error_count++;
            $display("%0t: sorted_value expected %0d actual %0d", $time,
                     reply_due.value, $signed(m_tdata));
          end
          if (m_tuser !== reply_due.err) begin
            error_count++;
            $display("%0t: index_error expected %0b actual %0b", $time,
                     reply_due.err, m_tuser);
          end
        end
      end
      m_tready <= !take_break();
    end
  end

  initial begin
    int n;
    int k;
    int i;
    bit big_done;
    big_done = 1'b0;

    // Directed: reads with nothing loaded, a one-value set, then a set with both extremes,
    // duplicates, a read before the sort and reads at and past the count.
    push_read(0, 1'b0);
    push_read(IDX_W'('1), 1'b0);
    push_load(32'sh7FFF_FFFF, 1'b1, 1'b0);
    push_read(0, 1'b0);
    push_read(1, 1'b0);
    push_load(32'sh8000_0000, 1'b0, 1'b1);
    push_load(32'sh7FFF_FFFF, 1'b0, 1'b0);
    push_read(0, 1'b0);
    push_load(0, 1'b0, 1'b0);
    push_load(-1, 1'b0, 1'b0);
    push_load(1, 1'b0, 1'b0);
    push_load(32'sh8000_0000, 1'b1, 1'b0);
    for (i = 0; i < 7; i++) push_read(i, 1'b0);
    push_read(IDX_W'('1), 1'b0);

    // Random: whole sets with random content, stray reads while a set is still open,
    // and one set that runs past capacity with the last mark on a dropped load.
    while (pending_reqs.size() < ITEM_TARGET) begin
      if (!big_done && pending_reqs.size() > 300) begin
        big_done = 1'b1;
        for (i = 0; i < CAPACITY + 3; i++) push_load(pick_value(), i == CAPACITY + 2, 1'b0);
        push_read(0, 1'b0);
        push_read(CAPACITY - 1, 1'b0);
        for (i = 0; i < 60; i++) push_read($urandom_range(0, CAPACITY - 1), 1'b0);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 19) == 0) push_read($urandom_range(0, CAPACITY - 1), 1'b0);
          push_load(pick_value(), i == n - 1, i == 0 && $urandom_range(0, 3) == 0);
        end
        k = $urandom_range(1, 12);
        for (i = 0; i < k; i++) begin
          case ($urandom_range(0, 9))
            0:       push_read($urandom_range(0, CAPACITY - 1), 1'b0);
            1:       push_read($urandom_range(n, CAPACITY - 1), 1'b0);
            default: push_read($urandom_range(0, n - 1), 1'b0);
          endcase
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the stream to drain, bounded by the cycle limit.
    forever begin
      @(negedge clk);
      if (cycle > CYCLE_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
      if (pending_reqs.size() == 0 && !s_tvalid && reads_issued == results_seen) break;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    if (reply_queue.size() != 0) begin
      error_count++;
      $display("%0t: %0d replies never arrived", $time, reply_queue.size());
    end

    if (!timed_out && error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_merge.sv
rtl/merge_sort_engine_core.sv
verif/merge_sort_engine_core_test.sv
